// ===== src/rars_pkg.sv =====
// ============================================================================
// rars_pkg
// Shared types and constants for the range-add / range-sum segment tree.
// ============================================================================
package rars_pkg;

    // Tree geometry
    localparam int unsigned SIZE        = 65536;
    localparam int unsigned POS_W       = 17;
    localparam int unsigned NODE_W      = 19;
    localparam int unsigned SUM_W       = 64;
    localparam int unsigned AMT_W       = 32;
    localparam int unsigned SUM_DEPTH   = 2 * SIZE;
    localparam int unsigned SUM_AW      = 17;
    localparam int unsigned PEND_AW     = 16;
    localparam int unsigned MUL_W       = AMT_W + POS_W;
    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned SP_W        = 5;

    // Port widths
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [POS_W-1:0]   LEN_RESET = POS_W'(SIZE);
    localparam logic [SUM_AW-1:0]  CLR_LAST  = SUM_AW'(SUM_DEPTH - 1);

    // Operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register index (paddr[2])
    localparam logic REG_ACTIVE_LENGTH = 1'b0;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_VISIT,
        ST_Q_RD,
        ST_Q_ACC,
        ST_PD_RD,
        ST_PD_CHK,
        ST_T_RD,
        ST_T_MUL0,
        ST_T_MUL1,
        ST_T_WR,
        ST_DESCEND,
        ST_RET,
        ST_RC_RD0,
        ST_RC_RD1,
        ST_RC_WR,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        TAG_COVER,
        TAG_LEFT,
        TAG_RIGHT
    } tag_kind_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  lo;
        logic [POS_W-1:0]  hi;
        logic              phase;
    } frame_t;

    // Child node index; valid tree nodes stay below 2^18
    function automatic logic [NODE_W-1:0] child(input logic [NODE_W-1:0] node,
                                                input logic right);
        child = {node[NODE_W-2:0], right};
    endfunction

    // Split point of a segment
    function automatic logic [POS_W-1:0] seg_mid(input logic [POS_W-1:0] lo,
                                                 input logic [POS_W-1:0] hi);
        logic [POS_W:0] s;
        s = {1'b0, lo} + {1'b0, hi};
        seg_mid = s[POS_W:1];
    endfunction

    function automatic logic sum_ok(input logic [NODE_W-1:0] node);
        sum_ok = (node < NODE_W'(SUM_DEPTH));
    endfunction

    function automatic logic pend_ok(input logic [NODE_W-1:0] node);
        pend_ok = (node < NODE_W'(SIZE));
    endfunction

endpackage

// ===== src/rars_ram.sv =====
// ============================================================================
// rars_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module rars_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/range_add_range_sum_tree.sv =====
// ============================================================================
// range_add_range_sum_tree
// Lazy segment tree: range add of a signed value, range sum query (mod 2^64).
// ============================================================================
// Throughput: one item at a time; the next item is taken only once the
//   tree walk for the last one is back in idle.
// Reset: synchronous, active low. A clearing pass then zeroes both memories,
//   during which no item is taken.

module range_add_range_sum_tree (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: range_start[16:0], range_end[33:17], add_value[65:34], zero pad
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rars_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: operation[0]
    input  logic [0:0]                        s_tuser,
    // m_tdata: range_sum[63:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rars_pkg::SUM_W-1:0]        m_tdata,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rars_pkg::PADDR_W-1:0]      paddr,
    input  logic [rars_pkg::PDATA_W-1:0]      pwdata,
    output logic [rars_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    import rars_pkg::*;

    state_t              state_reg, state_next;
    logic [SUM_AW-1:0]   clr_reg;
    logic [POS_W-1:0]    active_length_reg;

    // Item registers
    logic                op_reg;
    logic [POS_W-1:0]    a_reg, b_reg, n_reg;
    logic [SUM_W-1:0]    amt_reg;
    logic [SUM_W-1:0]    acc_reg;

    // Current node
    logic [NODE_W-1:0]   cur_node_reg;
    logic [POS_W-1:0]    cur_lo_reg, cur_hi_reg;

    // Return stack
    frame_t              stack_reg [STACK_DEPTH];
    logic [SP_W-1:0]     sp_reg;

    // Tag unit
    logic [NODE_W-1:0]   tnode_reg;
    logic [POS_W-1:0]    tlen_reg;
    logic [SUM_W-1:0]    tamt_reg;
    tag_kind_t           tkind_reg;
    logic [MUL_W-1:0]    prod_lo_reg;
    logic [SUM_W-1:0]    prod_reg;

    // Recompute
    logic [NODE_W-1:0]   rc_node_reg;
    logic [SUM_W-1:0]    left_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [SUM_W-1:0]    m_tdata_reg;

    // Memory ports
    logic                sum_we, sum_re, pend_we, pend_re;
    logic [SUM_AW-1:0]   sum_waddr, sum_raddr;
    logic [PEND_AW-1:0]  pend_waddr, pend_raddr;
    logic [SUM_W-1:0]    sum_wdata, sum_rdata, pend_wdata, pend_rdata;

    // Node geometry
    logic [POS_W-1:0]    cur_mid, cur_len, top_mid, eff_n;
    logic                disjoint, covered;
    frame_t              top;
    logic [NODE_W-1:0]   rc_c0, rc_c1;
    logic [AMT_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_out;
    logic [AMT_W-1:0]    hi_part;
    logic                cfg_wr;

    assign cur_mid  = seg_mid(cur_lo_reg, cur_hi_reg);
    assign cur_len  = cur_hi_reg - cur_lo_reg + POS_W'(1);
    assign disjoint = (b_reg < cur_lo_reg) || (a_reg > cur_hi_reg);
    assign covered  = (a_reg <= cur_lo_reg) && (b_reg >= cur_hi_reg);
    assign top      = stack_reg[sp_reg - SP_W'(1)];
    assign top_mid  = seg_mid(top.lo, top.hi);
    assign rc_c0    = child(rc_node_reg, 1'b0);
    assign rc_c1    = child(rc_node_reg, 1'b1);

    // Effective length: 0 acts as 1, above SIZE acts as SIZE
    always_comb begin
        if (active_length_reg == '0) begin
            eff_n = POS_W'(1);
        end else if (active_length_reg > POS_W'(SIZE)) begin
            eff_n = POS_W'(SIZE);
        end else begin
            eff_n = active_length_reg;
        end
    end

    // Shared multiplier: low half then high half of the amount
    assign mul_a   = (state_reg == ST_T_MUL0) ? tamt_reg[AMT_W-1:0] : tamt_reg[SUM_W-1:AMT_W];
    assign mul_out = MUL_W'(mul_a) * MUL_W'(tlen_reg);
    assign hi_part = mul_out[AMT_W-1:0] + AMT_W'(prod_lo_reg[MUL_W-1:AMT_W]);

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_LENGTH);
    assign prdata = (paddr[2] == REG_ACTIVE_LENGTH) ? PDATA_W'(active_length_reg) : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == CLR_LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_START;
            end
            ST_START: begin
                if (a_reg > b_reg) begin
                    state_next = (op_reg == OP_QUERY) ? ST_DONE : ST_IDLE;
                end else begin
                    state_next = ST_VISIT;
                end
            end
            ST_VISIT: begin
                if (disjoint) begin
                    state_next = ST_RET;
                end else if (covered) begin
                    state_next = (op_reg == OP_QUERY) ? ST_Q_RD : ST_T_RD;
                end else begin
                    state_next = pend_ok(cur_node_reg) ? ST_PD_RD : ST_DESCEND;
                end
            end
            ST_Q_RD:   state_next = ST_Q_ACC;
            ST_Q_ACC:  state_next = ST_RET;
            ST_PD_RD:  state_next = ST_PD_CHK;
            ST_PD_CHK: state_next = (pend_rdata == '0) ? ST_DESCEND : ST_T_RD;
            ST_T_RD:   state_next = ST_T_MUL0;
            ST_T_MUL0: state_next = ST_T_MUL1;
            ST_T_MUL1: state_next = ST_T_WR;
            ST_T_WR: begin
                case (tkind_reg)
                    TAG_COVER: state_next = ST_RET;
                    TAG_LEFT:  state_next = ST_T_RD;
                    TAG_RIGHT: state_next = ST_DESCEND;
                    default:   state_next = ST_RET;
                endcase
            end
            ST_DESCEND: state_next = ST_VISIT;
            ST_RET: begin
                if (sp_reg == '0) begin
                    state_next = (op_reg == OP_QUERY) ? ST_DONE : ST_IDLE;
                end else if (!top.phase) begin
                    state_next = ST_VISIT;
                end else begin
                    state_next = (op_reg == OP_QUERY) ? ST_RET : ST_RC_RD0;
                end
            end
            ST_RC_RD0: state_next = ST_RC_RD1;
            ST_RC_RD1: state_next = ST_RC_WR;
            ST_RC_WR:  state_next = ST_RET;
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory controls
    always_comb begin
        sum_we     = 1'b0;
        sum_re     = 1'b0;
        pend_we    = 1'b0;
        pend_re    = 1'b0;
        sum_waddr  = cur_node_reg[SUM_AW-1:0];
        sum_raddr  = cur_node_reg[SUM_AW-1:0];
        pend_waddr = cur_node_reg[PEND_AW-1:0];
        pend_raddr = cur_node_reg[PEND_AW-1:0];
        sum_wdata  = '0;
        pend_wdata = '0;
        case (state_reg)
            ST_CLEAR: begin
                sum_we     = 1'b1;
                sum_waddr  = clr_reg;
                pend_we    = (clr_reg < SUM_AW'(SIZE));
                pend_waddr = clr_reg[PEND_AW-1:0];
            end
            ST_Q_RD: sum_re = 1'b1;
            ST_PD_RD: pend_re = 1'b1;
            ST_PD_CHK: pend_we = (pend_rdata != '0);
            ST_T_RD: begin
                sum_re     = 1'b1;
                pend_re    = 1'b1;
                sum_raddr  = tnode_reg[SUM_AW-1:0];
                pend_raddr = tnode_reg[PEND_AW-1:0];
            end
            ST_T_WR: begin
                sum_we     = sum_ok(tnode_reg);
                sum_waddr  = tnode_reg[SUM_AW-1:0];
                sum_wdata  = sum_rdata + prod_reg;
                pend_we    = (tlen_reg > POS_W'(1)) && pend_ok(tnode_reg);
                pend_waddr = tnode_reg[PEND_AW-1:0];
                pend_wdata = pend_rdata + tamt_reg;
            end
            ST_RC_RD0: begin
                sum_re    = 1'b1;
                sum_raddr = rc_c0[SUM_AW-1:0];
            end
            ST_RC_RD1: begin
                sum_re    = 1'b1;
                sum_raddr = rc_c1[SUM_AW-1:0];
            end
            ST_RC_WR: begin
                sum_we    = sum_ok(rc_node_reg);
                sum_waddr = rc_node_reg[SUM_AW-1:0];
                sum_wdata = left_reg + (sum_ok(rc_c1) ? sum_rdata : '0);
            end
            default: ;
        endcase
    end

    // Control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            clr_reg           <= '0;
            sp_reg            <= '0;
            m_tvalid_reg      <= 1'b0;
            active_length_reg <= LEN_RESET;
        end else begin
            state_reg <= state_next;

            if (cfg_wr) active_length_reg <= pwdata[POS_W-1:0];

            // Output register
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= acc_reg;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + SUM_AW'(1);
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg  <= s_tuser[0];
                        a_reg   <= s_tdata[16:0];
                        b_reg   <= s_tdata[33:17];
                        amt_reg <= {{AMT_W{s_tdata[65]}}, s_tdata[65:34]};
                        n_reg   <= eff_n;
                    end
                end
                ST_START: begin
                    acc_reg      <= '0;
                    sp_reg       <= '0;
                    cur_node_reg <= NODE_W'(1);
                    cur_lo_reg   <= POS_W'(1);
                    cur_hi_reg   <= n_reg;
                end
                ST_VISIT: begin
                    tnode_reg <= cur_node_reg;
                    tlen_reg  <= cur_len;
                    tamt_reg  <= amt_reg;
                    tkind_reg <= TAG_COVER;
                end
                ST_Q_ACC: begin
                    acc_reg <= acc_reg + (sum_ok(cur_node_reg) ? sum_rdata : '0);
                end
                ST_PD_CHK: begin
                    tnode_reg <= child(cur_node_reg, 1'b0);
                    tlen_reg  <= cur_mid - cur_lo_reg + POS_W'(1);
                    tamt_reg  <= pend_rdata;
                    tkind_reg <= TAG_LEFT;
                end
                ST_T_MUL0: prod_lo_reg <= mul_out;
                ST_T_MUL1: prod_reg <= {hi_part, prod_lo_reg[AMT_W-1:0]};
                ST_T_WR: begin
                    if (tkind_reg == TAG_LEFT) begin
                        tnode_reg <= child(cur_node_reg, 1'b1);
                        tlen_reg  <= cur_hi_reg - cur_mid;
                        tkind_reg <= TAG_RIGHT;
                    end
                end
                ST_DESCEND: begin
                    stack_reg[sp_reg] <= '{node: cur_node_reg, lo: cur_lo_reg,
                                           hi: cur_hi_reg, phase: 1'b0};
                    sp_reg            <= sp_reg + SP_W'(1);
                    cur_node_reg      <= child(cur_node_reg, 1'b0);
                    cur_hi_reg        <= cur_mid;
                end
                ST_RET: begin
                    if (sp_reg != '0) begin
                        if (!top.phase) begin
                            stack_reg[sp_reg - SP_W'(1)].phase <= 1'b1;
                            cur_node_reg <= child(top.node, 1'b1);
                            cur_lo_reg   <= top_mid + POS_W'(1);
                            cur_hi_reg   <= top.hi;
                        end else begin
                            sp_reg      <= sp_reg - SP_W'(1);
                            rc_node_reg <= top.node;
                        end
                    end
                end
                ST_RC_RD1: left_reg <= sum_ok(rc_c0) ? sum_rdata : '0;
                default: ;
            endcase
        end
    end

    // Node sums, one per tree node
    rars_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SUM_DEPTH)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // Pending per-position adds, one per internal node
    rars_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SIZE)
    ) u_pend_ram (
        .aclk  (aclk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .re    (pend_re),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

endmodule

// ===== src/rars_checker.sv =====
// ============================================================================
// rars_checker
// Port-level checks for the range-add / range-sum tree, bound to the top.
// ============================================================================
module rars_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rars_pkg::SUM_W-1:0]        m_tdata
);

    import rars_pkg::*;

    // Clearing pass follows reset: no item taken right after it
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("item ready during clearing pass");

    // One item at a time: taking an item closes the input
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after an item was taken");

    // A result is loaded only while the block is busy with its item
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while the block was idle");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind range_add_range_sum_tree rars_checker u_rars_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/range_add_range_sum_tree_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// range_add_range_sum_tree_tb
// Self-checking bench for the lazy segment tree (range add, range sum).
// A local tree model predicts every query sum. Items are sent in random
// bursts and results are taken under a random stall pattern. Phases run at
// several active lengths, including the extremes and out-of-range values.
// ============================================================================

module range_add_range_sum_tree_tb;
    import rars_pkg::*;

    localparam int unsigned TREE_N = SIZE;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [SUM_W-1:0]     m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    range_add_range_sum_tree dut (.*);

    // Clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Tree model state
    logic [63:0]      tree_sum [2*TREE_N];
    logic [63:0]      tree_pend [TREE_N];
    logic [POS_W-1:0] span_reg;
    logic [63:0]      sum_q [$];
    int               err_count;
    int               burst_left;
    bit               hold_req;

    function automatic int unsigned span_len();
        int unsigned n;
        n = span_reg;
        if (n < 1) n = 1;
        if (n > TREE_N) n = TREE_N;
        return n;
    endfunction

    function automatic logic [63:0] node_read(int unsigned node);
        return (node < 2 * TREE_N) ? tree_sum[node] : 64'd0;
    endfunction

    function automatic void tag_seg(int unsigned node, logic [63:0] len,
                                    logic [63:0] amt);
        if (node < 2 * TREE_N) tree_sum[node] += amt * len;
        if (len > 1 && node < TREE_N) tree_pend[node] += amt;
    endfunction

    function automatic void push_seg(int unsigned node, int unsigned lo,
                                     int unsigned mid, int unsigned hi);
        logic [63:0] p;
        if (node >= TREE_N) return;
        p = tree_pend[node];
        if (p != 0) begin
            tag_seg(2 * node, 64'(mid - lo + 1), p);
            tag_seg(2 * node + 1, 64'(hi - mid), p);
            tree_pend[node] = 64'd0;
        end
    endfunction

    function automatic void add_span(int unsigned node, int unsigned lo,
                                     int unsigned hi, int unsigned a,
                                     int unsigned b, logic [63:0] amt);
        int unsigned mid;
        if (b < lo || a > hi) return;
        if (a <= lo && b >= hi) begin
            tag_seg(node, 64'(hi - lo + 1), amt);
            return;
        end
        mid = (lo + hi) / 2;
        push_seg(node, lo, mid, hi);
        add_span(2 * node, lo, mid, a, b, amt);
        add_span(2 * node + 1, mid + 1, hi, a, b, amt);
        if (node < 2 * TREE_N) tree_sum[node] = node_read(2 * node) + node_read(2 * node + 1);
    endfunction

    function automatic logic [63:0] sum_span(int unsigned node, int unsigned lo,
                                             int unsigned hi, int unsigned a,
                                             int unsigned b);
        int unsigned mid;
        logic [63:0] left;
        if (b < lo || a > hi) return 64'd0;
        if (a <= lo && b >= hi) return node_read(node);
        mid = (lo + hi) / 2;
        push_seg(node, lo, mid, hi);
        left = sum_span(2 * node, lo, mid, a, b);
        return left + sum_span(2 * node + 1, mid + 1, hi, a, b);
    endfunction

    // Apply one accepted item to the model
    function automatic void model_item(logic op, logic [POS_W-1:0] a,
                                       logic [POS_W-1:0] b, logic [31:0] v);
        logic [63:0] amt;
        amt = {{32{v[31]}}, v};
        if (op == OP_ADD) begin
            if (a <= b) add_span(1, 1, span_len(), a, b, amt);
        end else begin
            sum_q = {sum_q, ((a <= b) ? sum_span(1, 1, span_len(), a, b) : 64'd0)};
        end
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        err_count++;
    endtask

    // Send one item; random bursts with gaps between them
    task automatic send_item(logic op, logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                             logic [31:0] v);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, v, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_item(op, a, b, v);
    endtask

    // Wait until the block is idle (adds leave no result to wait for)
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sum_q.size() != 0) @(posedge aclk);
        repeat (1500) @(posedge aclk);
    endtask

    task automatic write_length(logic [PDATA_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({REG_ACTIVE_LENGTH, 2'b00});
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        span_reg = val[POS_W-1:0];
    endtask

    // Endpoint mostly inside the tree, sometimes any 17-bit value
    function automatic logic [POS_W-1:0] pick_pos();
        if ($urandom_range(0, 9) == 0) return POS_W'($urandom);
        return POS_W'($urandom_range(0, span_len() + 2));
    endfunction

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(int count);
        logic [POS_W-1:0] a;
        logic [POS_W-1:0] b;
        logic [POS_W-1:0] t;
        repeat (count) begin
            a = pick_pos();
            b = pick_pos();
            // mostly ordered ranges, some left empty
            if (a > b && $urandom_range(0, 4) != 0) begin
                t = a;
                a = b;
                b = t;
            end
            send_item(logic'($urandom_range(0, 1)), a, b, pick_val());
        end
    endtask

    task automatic test_directed();
        send_item(OP_QUERY, 17'd1, 17'd65536, 32'd0);
        send_item(OP_ADD, 17'd1, 17'd65536, 32'h7FFF_FFFF);
        send_item(OP_QUERY, 17'd1, 17'd65536, 32'd0);
        send_item(OP_ADD, 17'd1, 17'd65536, 32'h8000_0000);
        send_item(OP_QUERY, 17'd1, 17'd1, 32'd0);
        send_item(OP_ADD, 17'd65536, 17'd65536, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 17'd65536, 17'd65536, 32'd0);
        // start of zero acts as one
        send_item(OP_ADD, 17'd0, 17'd3, 32'd5);
        send_item(OP_QUERY, 17'd0, 17'd2, 32'd0);
        // empty ranges
        send_item(OP_ADD, 17'd9, 17'd8, 32'd77);
        send_item(OP_QUERY, 17'd9, 17'd8, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 17'h1FFFF, 17'd0, 32'd0);
        // beyond the active length
        send_item(OP_ADD, 17'd65530, 17'h1FFFF, 32'd1234);
        send_item(OP_QUERY, 17'd65000, 17'h1FFFF, 32'd0);
        send_item(OP_QUERY, 17'h1FFFF, 17'h1FFFF, 32'd0);
        send_item(OP_ADD, 17'd32768, 17'd32769, 32'h5555_5555);
        send_item(OP_QUERY, 17'd32767, 17'd32770, 32'hAAAA_AAAA);
        send_item(OP_QUERY, 17'd1, 17'd65536, 32'd0);
        drain();
    endtask

    task automatic test_lengths();
        logic [PDATA_W-1:0] lens [7] = '{32'd1, 32'd0, 32'd2, 32'd37, 32'd1000,
                                         32'h1FFFF, 32'd65536};
        foreach (lens[i]) begin
            write_length(lens[i]);
            random_items(i < 3 ? 40 : 100);
            drain();
        end
    endtask

    // Receiver held off while the sender keeps offering queries
    task automatic test_pressure();
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(OP_QUERY, POS_W'($urandom_range(1, 100)),
                      POS_W'($urandom_range(100, 65536)), 32'd0);
        drain();
    endtask

    // Receiver stall pattern plus one long hold-off
    initial begin
        int hold;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (hold = 0; hold < 4000; hold++) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
        end
    end

    // Result check
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (sum_q.size() == 0) begin
                report("unexpected range_sum", m_tdata, 64'd0);
            end else begin
                logic [63:0] want;
                want = sum_q.pop_front();
                if (m_tdata !== want) report("range_sum", m_tdata, want);
            end
        end
    end

    // Run limit
    initial begin
        #50ms;
        $display("range_add_range_sum_tree test failed");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        err_count  = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        span_reg   = LEN_RESET;
        foreach (tree_sum[i]) tree_sum[i] = 64'd0;
        foreach (tree_pend[i]) tree_pend[i] = 64'd0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_lengths();
        test_pressure();
        write_length(32'd65536);
        random_items(170);
        drain();

        if (err_count == 0 && sum_q.size() == 0) begin
            $display("range_add_range_sum_tree test passed");
        end else begin
            $display("range_add_range_sum_tree test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/rars_pkg.sv
src/rars_ram.sv
src/range_add_range_sum_tree.sv
src/rars_checker.sv
verif/range_add_range_sum_tree_tb.sv
